// File: hdl/btm_pkg.sv
// btm_pkg: shared widths, register map, reset values and payload structs
// for the battery trimmed-mean monitor; no dependencies
package btm_pkg;

   localparam int UV_W    = 22;   // sample width, microvolts
   localparam int SUM_W   = 27;   // running sum of one burst
   localparam int MV_W    = 16;   // millivolt fields and registers
   localparam int DELTA_W = 12;   // hysteresis delta register
   localparam int CNT_W   = 3;    // low-reading run counter

   // microvolts to millivolts is *2/1000; 1000 is even so this folds to /500
   localparam int MV_NUM = 2;
   localparam int MV_DEN = 1000;

   localparam logic [CNT_W-1:0] LOW_COUNT_MAX  = CNT_W'(6);
   localparam logic [CNT_W-1:0] LOW_COUNT_TRIP = CNT_W'(5);

   // register map, one 32 bit word per register
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_MV        = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LOW_MV         = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_HIGH_MV = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_LOW_MV  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_DELTA   = CSR_IDX_W'(4);

   localparam logic [MV_W-1:0]    FULL_MV_RESET        = MV_W'(4200);
   localparam logic [MV_W-1:0]    LOW_MV_RESET         = MV_W'(3400);
   localparam logic [MV_W-1:0]    CHARGE_HIGH_MV_RESET = MV_W'(4100);
   localparam logic [MV_W-1:0]    CHARGE_LOW_MV_RESET  = MV_W'(3500);
   localparam logic [DELTA_W-1:0] CHARGE_DELTA_RESET   = DELTA_W'(200);

   typedef struct packed {
      logic [MV_W-1:0]    full_mv;
      logic [MV_W-1:0]    low_mv;
      logic [MV_W-1:0]    charge_high_mv;
      logic [MV_W-1:0]    charge_low_mv;
      logic [DELTA_W-1:0] charge_delta_mv;
   } cfg_type;

   // finished burst, handed from the accumulator to the scaler
   typedef struct packed {
      logic [SUM_W-1:0] sum_uv;
      logic [UV_W-1:0]  max_uv;
      logic [UV_W-1:0]  min_uv;
      logic             device_off;
   } burst_type;

   // scaled level, handed from the scaler to the charge tracker
   typedef struct packed {
      logic [MV_W-1:0] level_mv;
      logic            device_off;
   } level_type;

endpackage

// File: hdl/btm_if.sv
// btm_if: valid/ready channel interfaces for samples and results
// depends on btm_pkg
interface btm_req_if import btm_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [UV_W-1:0] sample_uv;
   logic            device_off;

   modport source (output valid, sample_uv, device_off, input ready);
   modport sink (input valid, sample_uv, device_off, output ready);
endinterface

interface btm_rsp_if import btm_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [MV_W-1:0] battery_mv;
   logic            charging;
   logic            low_battery;
   logic            shutdown_request;

   modport source (output valid, battery_mv, charging, low_battery, shutdown_request,
                   input ready);
   modport sink (input valid, battery_mv, charging, low_battery, shutdown_request,
                 output ready);
endinterface

// File: hdl/battery_trimmed_mean_monitor.sv
// battery_trimmed_mean_monitor: top level, register block and the
// accumulate, scale and charge stages; depends on btm_pkg, btm_if and submodules
//
// usage
//  - req_chan carries one ADC sample in microvolts plus the device-off flag per
//    transaction; a sample is taken every cycle that valid and ready are high
//  - every SAMPLES-th sample closes a burst; the largest and smallest sample are
//    dropped, the rest averaged and scaled by 2/1000 to millivolts
//  - rsp_chan carries one result transaction per burst; samples inside a burst
//    give no result
//  - the closing sample's burst is registered in turn in the burst register,
//    trimmed sum, reciprocal product, corrected quotient and result register
//  - throughput: one sample per cycle, fully pipelined, unless a closing sample waits;
//    the divide by 500*(SAMPLES-2) is a constant reciprocal multiply, one correction
//  - when rsp_chan stalls, the result is held and the three pipeline stages
//    fill behind it; samples keep flowing until a closing sample finds the
//    accumulator's output still occupied
//  - reset (synchronous) empties the pipeline, restarts the burst, clears the
//    charge tracking and low-reading count and loads the register defaults
//  - registers sit at byte address 4*index on the APB-style port; write only
//    while no transaction is in flight
module battery_trimmed_mean_monitor import btm_pkg::*; #(
   parameter int SAMPLES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   btm_req_if.sink               req_chan,
   btm_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration registers
   cfg_type              cfg_ff;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   // accumulator to scaler
   logic      burst_valid, burst_ready;
   burst_type burst;

   // scaler to charge tracker
   logic      level_valid, level_ready;
   level_type level;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_mv         <= FULL_MV_RESET;
         cfg_ff.low_mv          <= LOW_MV_RESET;
         cfg_ff.charge_high_mv  <= CHARGE_HIGH_MV_RESET;
         cfg_ff.charge_low_mv   <= CHARGE_LOW_MV_RESET;
         cfg_ff.charge_delta_mv <= CHARGE_DELTA_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            REG_FULL_MV:        cfg_ff.full_mv         <= pwdata[MV_W-1:0];
            REG_LOW_MV:         cfg_ff.low_mv          <= pwdata[MV_W-1:0];
            REG_CHARGE_HIGH_MV: cfg_ff.charge_high_mv  <= pwdata[MV_W-1:0];
            REG_CHARGE_LOW_MV:  cfg_ff.charge_low_mv   <= pwdata[MV_W-1:0];
            REG_CHARGE_DELTA:   cfg_ff.charge_delta_mv <= pwdata[DELTA_W-1:0];
            default: ;  // unmapped words ignore writes
         endcase
      end
   end

   // read back, unmapped words read zero
   always_comb begin
      case (csr_idx)
         REG_FULL_MV:        prdata = CSR_DATA_W'(cfg_ff.full_mv);
         REG_LOW_MV:         prdata = CSR_DATA_W'(cfg_ff.low_mv);
         REG_CHARGE_HIGH_MV: prdata = CSR_DATA_W'(cfg_ff.charge_high_mv);
         REG_CHARGE_LOW_MV:  prdata = CSR_DATA_W'(cfg_ff.charge_low_mv);
         REG_CHARGE_DELTA:   prdata = CSR_DATA_W'(cfg_ff.charge_delta_mv);
         default:            prdata = '0;
      endcase
   end

   // running sum and extremes of the current burst
   btm_accum #(
      .SAMPLES (SAMPLES)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .sample_uv  (req_chan.sample_uv),
      .device_off (req_chan.device_off),
      .out_valid  (burst_valid),
      .out_ready  (burst_ready),
      .out_burst  (burst)
   );

   // trim and scale to millivolts
   btm_scale #(
      .SAMPLES (SAMPLES)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (burst_valid),
      .in_ready  (burst_ready),
      .in_burst  (burst),
      .out_valid (level_valid),
      .out_ready (level_ready),
      .out_level (level)
   );

   // charge detection, clamp, low run count and result register
   btm_charge u_charge (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (level_valid),
      .in_ready         (level_ready),
      .in_level         (level),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .battery_mv       (rsp_chan.battery_mv),
      .charging         (rsp_chan.charging),
      .low_battery      (rsp_chan.low_battery),
      .shutdown_request (rsp_chan.shutdown_request)
   );

endmodule

// File: hdl/btm_accum.sv
// btm_accum: burst accumulator, running sum plus largest and smallest sample
// depends on btm_pkg
module btm_accum import btm_pkg::*; #(
   parameter int SAMPLES = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [UV_W-1:0] sample_uv,
   input  logic            device_off,
   output logic            out_valid,
   input  logic            out_ready,
   output burst_type       out_burst
);

   localparam int IDX_W = $clog2(SAMPLES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [UV_W-1:0]  max_ff, max_in;
   logic [UV_W-1:0]  min_ff, min_in;
   logic             out_valid_ff, out_valid_in;
   burst_type        burst_ff;
   logic             is_last;
   logic             accept;

   always_comb begin
      is_last  = (idx_ff == LAST_IDX);
      // only the closing sample needs room downstream
      in_ready = !(is_last && out_valid_ff && !out_ready);
      accept   = in_valid && in_ready;

      if (idx_ff == '0) begin
         sum_in = SUM_W'(sample_uv);
         max_in = sample_uv;
         min_in = sample_uv;
      end else begin
         sum_in = sum_ff + SUM_W'(sample_uv);
         max_in = (sample_uv > max_ff) ? sample_uv : max_ff;
         min_in = (sample_uv < min_ff) ? sample_uv : min_ff;
      end

      idx_in       = is_last ? '0 : idx_ff + IDX_W'(1);
      out_valid_in = out_valid_ff && !out_ready;
      if (accept && is_last) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
         min_ff       <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            idx_ff <= idx_in;
            sum_ff <= sum_in;
            max_ff <= max_in;
            min_ff <= min_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_last) begin
         burst_ff <= '{sum_uv: sum_in, max_uv: max_in, min_uv: min_in,
                       device_off: device_off};
      end
   end

   assign out_valid = out_valid_ff;
   assign out_burst = burst_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("burst position beyond last sample");

   a_trim_not_negative: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> burst_ff.sum_uv >= SUM_W'(burst_ff.max_uv) + SUM_W'(burst_ff.min_uv))
      else $error("burst sum smaller than its two extremes");

endmodule

// File: hdl/btm_scale.sv
// btm_scale: trims the burst and scales to millivolts by a constant
// reciprocal multiply with one correction step; depends on btm_pkg
module btm_scale import btm_pkg::*; #(
   parameter int SAMPLES = 8
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  burst_type in_burst,
   output logic      out_valid,
   input  logic      out_ready,
   output level_type out_level
);

   // mean over SAMPLES-2 then *2/1000, both truncating, is one floor division
   localparam int SCALE_DIV = (SAMPLES - 2) * (MV_DEN / MV_NUM);
   localparam int RECIP     = (2 ** SUM_W) / SCALE_DIV;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = SUM_W + RECIP_W;

   logic [RECIP_W-1:0] recip_c;
   logic [SUM_W-1:0]   div_c;

   // stage 1: trimmed sum
   logic             v1_ff;
   logic [SUM_W-1:0] trim_ff, trim_in;
   logic             off1_ff;
   // stage 2: reciprocal product
   logic              v2_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  trim2_ff;
   logic              off2_ff;
   // stage 3: corrected quotient
   logic               v3_ff;
   level_type          level_ff;
   logic [RECIP_W-1:0] quot_est;
   logic [SUM_W-1:0]   remain;
   logic [RECIP_W-1:0] quot_in;

   logic en1, en2, en3;

   always_comb begin
      recip_c = RECIP_W'(RECIP);
      div_c   = SUM_W'(SCALE_DIV);

      en3 = !v3_ff || out_ready;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;

      trim_in = in_burst.sum_uv - SUM_W'(in_burst.max_uv) - SUM_W'(in_burst.min_uv);
      prod_in = PROD_W'(trim_ff) * PROD_W'(recip_c);

      // estimate is exact or one short
      quot_est = prod_ff[PROD_W-1:SUM_W];
      remain   = trim2_ff - SUM_W'(quot_est) * div_c;
      quot_in  = quot_est + RECIP_W'(remain >= div_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         trim_ff <= trim_in;
         off1_ff <= in_burst.device_off;
      end
      if (en2) begin
         prod_ff  <= prod_in;
         trim2_ff <= trim_ff;
         off2_ff  <= off1_ff;
      end
      if (en3) begin
         level_ff <= '{level_mv: MV_W'(quot_in), device_off: off2_ff};
      end
   end

   assign in_ready  = en1;
   assign out_valid = v3_ff;
   assign out_level = level_ff;

endmodule

// File: hdl/btm_charge.sv
// btm_charge: charge hysteresis, clamp, low-reading run count and the
// result register; depends on btm_pkg
module btm_charge import btm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  level_type       in_level,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [MV_W-1:0] battery_mv,
   output logic            charging,
   output logic            low_battery,
   output logic            shutdown_request
);

   logic [MV_W-1:0]  tmin_ff, tmin_in;
   logic [MV_W-1:0]  tmax_ff, tmax_in;
   logic             trk_ff;
   logic             cs_ff, cs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]  mv_ff;
   logic             charging_ff, low_ff, shut_ff;

   logic            accept;
   logic [MV_W-1:0] level;
   logic [MV_W-1:0] tmin0, tmax0, tmin1, tmax1;
   logic [MV_W:0]   rise_lim, fall_lim;
   logic            flip;
   logic [MV_W-1:0] shown;
   logic            low, shut;

   always_comb begin
      in_ready = !rsp_valid_ff || rsp_ready;
      accept   = in_valid && in_ready;
      level    = in_level.level_mv;

      // first burst seeds both extremes
      tmin0 = trk_ff ? tmin_ff : level;
      tmax0 = trk_ff ? tmax_ff : level;

      rise_lim = {1'b0, tmin0} + (MV_W + 1)'(cfg.charge_delta_mv);
      fall_lim = {1'b0, level} + (MV_W + 1)'(cfg.charge_delta_mv);
      if (!cs_ff) begin
         flip = (level > cfg.charge_high_mv) || ({1'b0, level} > rise_lim);
      end else begin
         flip = (level < cfg.charge_low_mv) || ({1'b0, tmax0} > fall_lim);
      end
      cs_in = cs_ff ^ flip;
      tmin1 = flip ? level : tmin0;
      tmax1 = flip ? level : tmax0;
      tmin_in = (tmin1 > level) ? level : tmin1;
      tmax_in = (tmax1 < level) ? level : tmax1;

      shown = (level > cfg.full_mv) ? cfg.full_mv : level;
      low   = (shown <= cfg.low_mv);
      if (low) begin
         cnt_in = (cnt_ff < LOW_COUNT_MAX) ? cnt_ff + CNT_W'(1) : cnt_ff;
         shut   = (cnt_in > LOW_COUNT_TRIP) && !in_level.device_off;
      end else begin
         cnt_in = '0;
         shut   = 1'b0;
      end

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmin_ff      <= '0;
         tmax_ff      <= '0;
         trk_ff       <= 1'b0;
         cs_ff        <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tmin_ff <= tmin_in;
            tmax_ff <= tmax_in;
            trk_ff  <= 1'b1;
            cs_ff   <= cs_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mv_ff       <= shown;
         charging_ff <= cs_in;
         low_ff      <= low;
         shut_ff     <= shut;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign battery_mv       = mv_ff;
   assign charging         = charging_ff;
   assign low_battery      = low_ff;
   assign shutdown_request = shut_ff;

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LOW_COUNT_MAX)
      else $error("low-reading count past its ceiling");

   a_shutdown_on_full_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && shut_ff) |-> (low_ff && cnt_ff == LOW_COUNT_MAX))
      else $error("shutdown request without a full run of low readings");

   a_extremes_ordered: assert property (@(posedge clock) disable iff (reset)
      trk_ff |-> (tmin_ff <= tmax_ff && charging_ff == cs_ff))
      else $error("tracked extremes crossed or result disagrees with charge state");

endmodule
